[sv/arpc_pkg.sv]
// arpc_pkg: shared constants, codes and types for the ARP cache responder.
// No dependencies; compiled first.
package arpc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [10:0] MIN_FRAME   = 11'd28;
	localparam logic [15:0] HW_ETHERNET = 16'h0001;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [15:0] OP_REQUEST  = 16'h0001;
	localparam logic [31:0] TTL_RESET   = 32'd60000;
	localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] IP_ONES     = 32'hFFFF_FFFF;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		CMD_PACKET  = 2'd0,
		CMD_RESOLVE = 2'd1,
		CMD_ADD     = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_DROPPED = 2'd1,
		ACT_REPLY   = 2'd2,
		ACT_REQUEST = 2'd3
	} action_t;

	typedef enum logic [0:0] {
		REG_OWN_IP = 1'd0,
		REG_TTL_MS = 1'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SCAN,
		ST_RES_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

[sv/arpc_req_if.sv]
// arpc_req_if: request channel (valid/ready plus request fields).
// Depends on nothing; fixed field widths.
interface arpc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [10:0] frame_length;
	logic [15:0] hardware_type;
	logic [15:0] protocol_type;
	logic [15:0] arp_opcode;
	logic [31:0] src_ip;
	logic [47:0] src_mac;
	logic [31:0] dst_ip;
	logic [31:0] query_ip;
	logic [47:0] entry_mac;
	logic [31:0] current_time;

	modport source (
		output valid, cmd, frame_length, hardware_type, protocol_type, arp_opcode,
		       src_ip, src_mac, dst_ip, query_ip, entry_mac, current_time,
		input  ready
	);
	modport sink (
		input  valid, cmd, frame_length, hardware_type, protocol_type, arp_opcode,
		       src_ip, src_mac, dst_ip, query_ip, entry_mac, current_time,
		output ready
	);
endinterface

[sv/arpc_rsp_if.sv]
// arpc_rsp_if: response channel (valid/ready plus result fields).
// Depends on nothing; fixed field widths.
interface arpc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic        resolved;
	logic [47:0] resolved_mac;
	logic [31:0] send_ip;
	logic [47:0] send_mac;

	modport source (
		output valid, action, resolved, resolved_mac, send_ip, send_mac,
		input  ready
	);
	modport sink (
		input  valid, action, resolved, resolved_mac, send_ip, send_mac,
		output ready
	);
endinterface

[sv/arp_cache_responder.sv]
// Sequence after acceptance: a packet/add scans every slot, writes the chosen slot and then posts
// its response; a resolve scans until a valid IP match or the last slot; drops, broadcast resolves
// and the unused command post theirs directly. Throughput: one transaction at a time, one slot
// compared per cycle; the request side stays not ready until the response is posted. The result
// register lets the next request in while the last response waits. Reset (arst_n, async) clears
// the cache, sets own_ip 0 and ttl_ms 60000; no clearing pass is needed.
module arp_cache_responder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  arpc_pkg::reg_idx_t   wr_index,
	input  logic [31:0]          wr_data,
	arpc_req_if.sink             req,
	arpc_rsp_if.source           rsp
);
	import arpc_pkg::*;

	// Configuration
	logic [31:0] own_ip_q, ttl_ms_q;

	// Cache store, one slot read per cycle at the scan index
	logic        ent_valid_q [ENTRIES];
	logic [31:0] ent_ip_q    [ENTRIES];
	logic [47:0] ent_mac_q   [ENTRIES];
	logic [31:0] ent_stamp_q [ENTRIES];

	state_t state_q, state_d;

	// Working copy of the transaction
	logic [31:0] ip_q, now_q;
	logic [47:0] mac_q;
	idx_t        scan_q;

	// Insert slot search
	logic        match_f_q, free_f_q;
	idx_t        match_idx_q, free_idx_q, min_idx_q;
	logic [31:0] min_stamp_q;

	// Pending result
	action_t     res_action_q;
	logic        res_resolved_q;
	logic [47:0] res_rmac_q, res_smac_q;
	logic [31:0] res_sip_q;

	// Output register
	logic        out_valid_q;
	action_t     out_action_q;
	logic        out_resolved_q;
	logic [47:0] out_rmac_q, out_smac_q;
	logic [31:0] out_sip_q;

	// Shared compare step on the slot under the scan index
	logic        cur_valid, ip_eq, stamp_lt, last, res_hit, stale;
	logic [31:0] age;
	idx_t        tgt;
	logic        accept, cmd_bad_frame, cmd_bcast, out_free;

	assign cur_valid = ent_valid_q[scan_q];
	assign ip_eq     = (ent_ip_q[scan_q] == ip_q);
	assign stamp_lt  = (ent_stamp_q[scan_q] < min_stamp_q);
	assign age       = now_q - ent_stamp_q[scan_q];
	assign stale     = (age > ttl_ms_q);
	assign last      = (scan_q == idx_t'(ENTRIES - 1));
	assign res_hit   = cur_valid && ip_eq;
	assign tgt       = match_f_q ? match_idx_q : (free_f_q ? free_idx_q : min_idx_q);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign cmd_bad_frame = (req.frame_length < MIN_FRAME) || (req.hardware_type != HW_ETHERNET)
	                       || (req.protocol_type != PROTO_IPV4);
	assign cmd_bcast     = (req.query_ip == '0) || (req.query_ip == IP_ONES);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (cmd_t'(req.cmd))
						CMD_PACKET:  state_d = cmd_bad_frame ? ST_DONE : ST_INS_SCAN;
						CMD_RESOLVE: state_d = cmd_bcast ? ST_DONE : ST_RES_SCAN;
						CMD_ADD:     state_d = ST_INS_SCAN;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_INS_SCAN: begin
				if (last) state_d = ST_WRITE;
			end
			ST_WRITE: state_d = ST_DONE;
			ST_RES_SCAN: begin
				if (res_hit || last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
			ttl_ms_q <= TTL_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OWN_IP: own_ip_q <= wr_data;
				REG_TTL_MS: ttl_ms_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Cache store: cleared at reset, written once per insert, invalidated on stale hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				ent_valid_q[i] <= 1'b0;
				ent_ip_q[i]    <= '0;
				ent_mac_q[i]   <= '0;
				ent_stamp_q[i] <= '0;
			end
		end else if (state_q == ST_WRITE) begin
			ent_valid_q[tgt] <= 1'b1;
			ent_ip_q[tgt]    <= ip_q;
			ent_mac_q[tgt]   <= mac_q;
			ent_stamp_q[tgt] <= now_q;
		end else if (state_q == ST_RES_SCAN && res_hit && stale) begin
			ent_valid_q[scan_q] <= 1'b0;
		end
	end

	// Scan control and slot search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			match_f_q <= 1'b0;
			free_f_q  <= 1'b0;
		end else if (accept) begin
			scan_q    <= '0;
			match_f_q <= 1'b0;
			free_f_q  <= 1'b0;
		end else if (state_q == ST_INS_SCAN || state_q == ST_RES_SCAN) begin
			if (!last) scan_q <= scan_q + idx_t'(1);
			if (state_q == ST_INS_SCAN) begin
				if (!match_f_q && ip_eq) match_f_q <= 1'b1;
				if (!free_f_q && !cur_valid) free_f_q <= 1'b1;
			end
		end
	end

	// Payload side of the search; no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			ip_q  <= (cmd_t'(req.cmd) == CMD_PACKET) ? req.src_ip : req.query_ip;
			mac_q <= (cmd_t'(req.cmd) == CMD_PACKET) ? req.src_mac : req.entry_mac;
			now_q <= req.current_time;
		end else if (state_q == ST_INS_SCAN) begin
			if (!match_f_q && ip_eq) match_idx_q <= scan_q;
			if (!free_f_q && !cur_valid) free_idx_q <= scan_q;
			// first slot always seeds the oldest search; later ones need a strictly older stamp
			if (scan_q == '0 || stamp_lt) begin
				min_stamp_q <= ent_stamp_q[scan_q];
				min_idx_q   <= scan_q;
			end
		end
	end

	// Pending result: preset at accept, a resolve hit that is not stale overrides the miss default
	always_ff @(posedge clk) begin
		if (accept) begin
			res_action_q   <= ACT_NONE;
			res_resolved_q <= 1'b0;
			res_rmac_q     <= '0;
			res_sip_q      <= '0;
			res_smac_q     <= '0;
			case (cmd_t'(req.cmd))
				CMD_PACKET: begin
					if (cmd_bad_frame) begin
						res_action_q <= ACT_DROPPED;
					end else if (req.arp_opcode == OP_REQUEST && req.dst_ip == own_ip_q) begin
						res_action_q <= ACT_REPLY;
						res_sip_q    <= req.src_ip;
						res_smac_q   <= req.src_mac;
					end
				end
				CMD_RESOLVE: begin
					if (cmd_bcast) begin
						res_resolved_q <= 1'b1;
						res_rmac_q     <= MAC_BCAST;
					end else begin
						res_action_q <= ACT_REQUEST;
						res_sip_q    <= req.query_ip;
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_RES_SCAN && res_hit && !stale) begin
			res_action_q   <= ACT_NONE;
			res_sip_q      <= '0;
			res_resolved_q <= 1'b1;
			res_rmac_q     <= ent_mac_q[scan_q];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_action_q   <= res_action_q;
			out_resolved_q <= res_resolved_q;
			out_rmac_q     <= res_rmac_q;
			out_sip_q      <= res_sip_q;
			out_smac_q     <= res_smac_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.action       = out_action_q;
	assign rsp.resolved     = out_resolved_q;
	assign rsp.resolved_mac = out_rmac_q;
	assign rsp.send_ip      = out_sip_q;
	assign rsp.send_mac     = out_smac_q;

endmodule

[sim/tb.sv]
// tb: self-checking testbench for arp_cache_responder, with its own cache model.
// Depends on arpc_pkg, arpc_req_if, arpc_rsp_if and the arp_cache_responder RTL.
// Directed packet/resolve cases first, then randomized traffic under several register settings.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import arpc_pkg::*;

	// Long enough to back the block up and stall its request side.
	localparam int HOLD_CYCLES  = 300;
	// Drain wait at the end, well past the longest transaction (a full insert scan).
	localparam int DRAIN_CYCLES = 4 * ENTRIES + 20;
	localparam int CYCLE_LIMIT  = 300000;
	// More addresses than slots, so that eviction of the oldest stamp gets exercised.
	localparam int POOL_N       = 24;
	localparam logic [15:0] OP_REPLY = 16'h0002;

	typedef struct {
		cmd_t        cmd;
		logic [10:0] frame_length;
		logic [15:0] hardware_type;
		logic [15:0] protocol_type;
		logic [15:0] arp_opcode;
		logic [31:0] src_ip;
		logic [47:0] src_mac;
		logic [31:0] dst_ip;
		logic [31:0] query_ip;
		logic [47:0] entry_mac;
		logic [31:0] current_time;
	} arp_req_t;

	typedef struct {
		action_t     action;
		logic        resolved;
		logic [47:0] resolved_mac;
		logic [31:0] send_ip;
		logic [47:0] send_mac;
	} arp_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        wr_en;
	reg_idx_t    wr_index;
	logic [31:0] wr_data;

	arpc_req_if req();
	arpc_rsp_if rsp();

	arp_cache_responder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req),
		.rsp      (rsp)
	);

	// Cache model and register shadows.
	logic        cache_valid [ENTRIES];
	logic [31:0] cache_ip    [ENTRIES];
	logic [47:0] cache_mac   [ENTRIES];
	logic [31:0] cache_stamp [ENTRIES];
	logic [31:0] model_own_ip;
	logic [31:0] model_ttl_ms;

	// Expected responses, oldest first.
	arp_rsp_t pending_outcomes [$];

	int fail_count    = 0;
	int cycle_count   = 0;
	int src_idle_pct  = 14;
	int sink_idle_pct = 51;
	int time_step_max = 400;

	logic        rsp_hold = 1'b0;
	event        hold_trigger;
	logic [31:0] now_ms;
	logic [31:0] ip_pool [POOL_N];

	always #10 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Cache model
	// ---------------------------------------------------------------------

	// Merge or insert. An IP match wins even on an invalid slot; otherwise the
	// first free slot, else the first slot carrying the smallest stamp.
	function automatic void cache_insert(logic [31:0] ip, logic [47:0] mac,
			logic [31:0] stamp);
		int slot;
		logic [32:0] oldest;
		slot = -1;
		oldest = '1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot < 0 && cache_ip[i] == ip)
				slot = i;
		if (slot < 0) begin
			slot = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (!cache_valid[i]) begin
					slot = i;
					break;
				end
				if ({1'b0, cache_stamp[i]} < oldest) begin
					oldest = {1'b0, cache_stamp[i]};
					slot = i;
				end
			end
		end
		cache_ip[slot]    = ip;
		cache_mac[slot]   = mac;
		cache_stamp[slot] = stamp;
		cache_valid[slot] = 1'b1;
	endfunction

	// First valid match; a stale one (age past ttl, mod 2^32) is dropped and misses.
	function automatic int cache_find(logic [31:0] ip, logic [31:0] now);
		logic [31:0] age;
		for (int i = 0; i < ENTRIES; i++) begin
			if (cache_valid[i] && cache_ip[i] == ip) begin
				age = now - cache_stamp[i];
				if (age > model_ttl_ms) begin
					cache_valid[i] = 1'b0;
					return -1;
				end
				return i;
			end
		end
		return -1;
	endfunction

	function automatic arp_rsp_t responder_outcome(arp_req_t r);
		arp_rsp_t o;
		int hit;
		o = '{ACT_NONE, 1'b0, 48'd0, 32'd0, 48'd0};
		case (r.cmd)
			CMD_PACKET: begin
				if (r.frame_length < MIN_FRAME || r.hardware_type != HW_ETHERNET ||
						r.protocol_type != PROTO_IPV4) begin
					o.action = ACT_DROPPED;
				end else begin
					cache_insert(r.src_ip, r.src_mac, r.current_time);
					if (r.arp_opcode == OP_REQUEST && r.dst_ip == model_own_ip) begin
						o.action   = ACT_REPLY;
						o.send_ip  = r.src_ip;
						o.send_mac = r.src_mac;
					end
				end
			end
			CMD_RESOLVE: begin
				if (r.query_ip == 32'd0 || r.query_ip == IP_ONES) begin
					o.resolved     = 1'b1;
					o.resolved_mac = MAC_BCAST;
				end else begin
					hit = cache_find(r.query_ip, r.current_time);
					if (hit >= 0) begin
						o.resolved     = 1'b1;
						o.resolved_mac = cache_mac[hit];
					end else begin
						o.action  = ACT_REQUEST;
						o.send_ip = r.query_ip;
					end
				end
			end
			CMD_ADD: cache_insert(r.query_ip, r.entry_mac, r.current_time);
			default: ;
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------------
	// Request builders
	// ---------------------------------------------------------------------

	function automatic arp_req_t make_packet(logic [10:0] flen, logic [15:0] hw,
			logic [15:0] proto, logic [15:0] op, logic [31:0] sip, logic [47:0] smac,
			logic [31:0] tip, logic [31:0] stamp);
		arp_req_t r;
		r = '{CMD_PACKET, flen, hw, proto, op, sip, smac, tip, 32'd0, 48'd0, stamp};
		return r;
	endfunction

	function automatic arp_req_t make_query(cmd_t c, logic [31:0] ip, logic [47:0] mac,
			logic [31:0] stamp);
		arp_req_t r;
		r = '{c, 11'd0, 16'd0, 16'd0, 16'd0, 32'd0, 48'd0, 32'd0, ip, mac, stamp};
		return r;
	endfunction

	// Mostly well-formed traffic over a small address pool; the rest is broken
	// headers, short frames, odd opcodes, arbitrary queries and the unused command.
	function automatic arp_req_t random_request();
		arp_req_t r;
		int pick;
		if ($urandom_range(99) < 3)
			now_ms = $urandom;
		else
			now_ms = now_ms + 32'($urandom_range(0, time_step_max));
		r.frame_length  = 11'($urandom_range(MIN_FRAME, 2047));
		r.hardware_type = HW_ETHERNET;
		r.protocol_type = PROTO_IPV4;
		r.arp_opcode    = ($urandom_range(9) < 6) ? OP_REQUEST : OP_REPLY;
		r.src_ip        = ip_pool[$urandom_range(0, POOL_N - 1)];
		r.src_mac       = {16'($urandom), 32'($urandom)};
		r.dst_ip        = $urandom_range(1) ? model_own_ip : ip_pool[$urandom_range(0, POOL_N - 1)];
		r.query_ip      = ip_pool[$urandom_range(0, POOL_N - 1)];
		r.entry_mac     = {16'($urandom), 32'($urandom)};
		r.current_time  = now_ms;

		pick = $urandom_range(99);
		if (pick < 45)
			r.cmd = CMD_PACKET;
		else if (pick < 80)
			r.cmd = CMD_RESOLVE;
		else if (pick < 95)
			r.cmd = CMD_ADD;
		else
			r.cmd = CMD_UNUSED;

		pick = $urandom_range(99);
		if (pick < 4) begin
			r.frame_length = 11'($urandom_range(0, MIN_FRAME - 1));
		end else if (pick < 8) begin
			r.hardware_type = 16'($urandom);
		end else if (pick < 12) begin
			r.protocol_type = 16'($urandom);
		end else if (pick < 20) begin
			r.arp_opcode = 16'($urandom);
		end else if (pick < 30) begin
			r.query_ip = $urandom;
		end else if (pick < 34) begin
			r.query_ip = $urandom_range(1) ? IP_ONES : 32'd0;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------------

	// valid is left high after acceptance; the next call or wait_for_idle
	// decides whether it drops, so it never sees two updates in one step.
	task automatic send_request(arp_req_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid         <= 1'b1;
		req.cmd           <= r.cmd;
		req.frame_length  <= r.frame_length;
		req.hardware_type <= r.hardware_type;
		req.protocol_type <= r.protocol_type;
		req.arp_opcode    <= r.arp_opcode;
		req.src_ip        <= r.src_ip;
		req.src_mac       <= r.src_mac;
		req.dst_ip        <= r.dst_ip;
		req.query_ip      <= r.query_ip;
		req.entry_mac     <= r.entry_mac;
		req.current_time  <= r.current_time;
		do @(posedge clk); while (req.ready !== 1'b1);
		pending_outcomes.push_back(responder_outcome(r));
	endtask

	// Every request yields one response, so an empty queue means the block is idle.
	task automatic wait_for_idle();
		req.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_registers(logic [31:0] own, logic [31:0] ttl);
		wr_en    <= 1'b1;
		wr_index <= REG_OWN_IP;
		wr_data  <= own;
		@(posedge clk);
		wr_index <= REG_TTL_MS;
		wr_data  <= ttl;
		@(posedge clk);
		wr_en <= 1'b0;
		model_own_ip = own;
		model_ttl_ms = ttl;
	endtask

	// ---------------------------------------------------------------------
	// Response side: random ready, long hold on request, field checks
	// ---------------------------------------------------------------------

	function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endfunction

	initial begin
		arp_rsp_t want;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (pending_outcomes.size() == 0) begin
					$error("response transaction with no request outstanding");
					fail_count++;
				end else begin
					want = pending_outcomes.pop_front();
					check_field("action", 48'(want.action), 48'(rsp.action));
					check_field("resolved", 48'(want.resolved), 48'(rsp.resolved));
					check_field("resolved_mac", want.resolved_mac, rsp.resolved_mac);
					check_field("send_ip", 48'(want.send_ip), 48'(rsp.send_ip));
					check_field("send_mac", want.send_mac, rsp.send_mac);
				end
			end
			rsp.ready <= !rsp_hold && ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Holds the response side off for a fixed stretch once triggered.
	initial forever begin
		@(hold_trigger);
		rsp_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Runs on reset register values: own_ip 0, ttl 60000.
	task automatic test_packet_filtering();
		send_request(make_query(CMD_UNUSED, IP_ONES, MAC_BCAST, IP_ONES));
		// drops: short frame at the boundary, empty frame, wrong hw and protocol types
		send_request(make_packet(MIN_FRAME - 1, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
			32'h0A00_0002, 48'h0200_0000_0002, 32'd0, 32'd900));
		send_request(make_packet(11'd0, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
			32'h0A00_0002, 48'h0200_0000_0002, 32'd0, 32'd900));
		send_request(make_packet(MIN_FRAME, 16'h0002, PROTO_IPV4, OP_REQUEST,
			32'h0A00_0002, 48'h0200_0000_0002, 32'd0, 32'd900));
		send_request(make_packet(MIN_FRAME, HW_ETHERNET, 16'h86DD, OP_REQUEST,
			32'h0A00_0002, 48'h0200_0000_0002, 32'd0, 32'd900));
		send_request(make_packet(11'h7FF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			32'h0A00_0002, 48'h0200_0000_0002, 32'd0, 32'd900));
		// request aimed at us: reply
		send_request(make_packet(MIN_FRAME, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
			32'h0A00_0002, 48'h0200_0000_0002, 32'd0, 32'd1000));
		// request for someone else, and a reply opcode aimed at us: merge only
		send_request(make_packet(11'h7FF, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
			32'h0A00_0003, 48'h0200_0000_0003, 32'h0A00_0099, 32'd1100));
		send_request(make_packet(MIN_FRAME, HW_ETHERNET, PROTO_IPV4, OP_REPLY,
			32'h0A00_0004, 48'h0200_0000_0004, 32'd0, 32'd1200));
		send_request(make_packet(11'h7FF, HW_ETHERNET, PROTO_IPV4, 16'd0,
			IP_ONES, MAC_BCAST, IP_ONES, IP_ONES));
	endtask

	task automatic test_resolve_paths();
		send_request(make_query(CMD_RESOLVE, 32'd0, 48'd0, 32'd1500));
		send_request(make_query(CMD_RESOLVE, IP_ONES, 48'd0, 32'd1500));
		send_request(make_query(CMD_RESOLVE, 32'h0A00_0002, 48'd0, 32'd1500));
		send_request(make_query(CMD_RESOLVE, 32'h0A00_00AA, 48'd0, 32'd1500));
		// age exactly at ttl still hits, one past is stale and gets invalidated
		send_request(make_query(CMD_ADD, 32'h0A00_0005, 48'hA5A5_5A5A_0005, 32'd2000));
		send_request(make_query(CMD_RESOLVE, 32'h0A00_0005, 48'd0, 32'd62000));
		send_request(make_query(CMD_RESOLVE, 32'h0A00_0005, 48'd0, 32'd62001));
		send_request(make_query(CMD_RESOLVE, 32'h0A00_0005, 48'd0, 32'd62001));
		// add onto the invalidated slot by IP match
		send_request(make_query(CMD_ADD, 32'h0A00_0005, 48'h5A5A_A5A5_0005, 32'd62001));
		// IP 0 matches a never-used slot
		send_request(make_query(CMD_ADD, 32'd0, 48'h0000_0000_0001, 32'd5));
		// timestamp wrap: age is taken modulo 2^32
		send_request(make_query(CMD_ADD, 32'h0A00_0006, 48'h0200_0000_0006, 32'hFFFF_FF00));
		send_request(make_query(CMD_RESOLVE, 32'h0A00_0006, 48'd0, 32'h0000_0010));
		send_request(make_packet(MIN_FRAME, HW_ETHERNET, PROTO_IPV4, OP_REQUEST,
			32'd0, 48'h0200_0000_0000, 32'h0A00_0001, 32'd0));
	endtask

	task automatic test_random_traffic(int count, logic [31:0] own, logic [31:0] ttl,
			int step_max, int src_pct, int sink_pct);
		wait_for_idle();
		set_registers(own, ttl);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		time_step_max = step_max;
		now_ms = $urandom;
		ip_pool[0] = 32'd0;
		for (int i = 1; i < POOL_N; i++)
			ip_pool[i] = $urandom;
		for (int n = 0; n < count; n++)
			send_request(random_request());
	endtask

	// Response side held off while requests keep coming; then the sender
	// pauses until every outstanding response has drained.
	task automatic test_backpressure(int count);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		-> hold_trigger;
		for (int n = 0; n < count; n++)
			send_request(random_request());
		wait_for_idle();
	endtask

	initial begin
		arst_n             <= 1'b0;
		wr_en              <= 1'b0;
		wr_index           <= REG_OWN_IP;
		wr_data            <= '0;
		req.valid          <= 1'b0;
		req.cmd            <= CMD_PACKET;
		req.frame_length   <= '0;
		req.hardware_type  <= '0;
		req.protocol_type  <= '0;
		req.arp_opcode     <= '0;
		req.src_ip         <= '0;
		req.src_mac        <= '0;
		req.dst_ip         <= '0;
		req.query_ip       <= '0;
		req.entry_mac      <= '0;
		req.current_time   <= '0;
		model_own_ip = 32'd0;
		model_ttl_ms = TTL_RESET;
		for (int i = 0; i < ENTRIES; i++) begin
			cache_valid[i] = 1'b0;
			cache_ip[i]    = '0;
			cache_mac[i]   = '0;
			cache_stamp[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_packet_filtering();
		test_resolve_paths();
		// sender idles 14%, receiver 51%
		test_random_traffic(330, 32'h0A00_0001, 32'd5000, 400, 14, 51);
		// roles swapped; ttl 0 so anything older than the current tick is stale
		test_random_traffic(330, IP_ONES, 32'd0, 1, 51, 14);
		// no idling from here on; ttl max never expires
		test_random_traffic(240, $urandom, 32'hFFFF_FFFF, 100000, 0, 0);
		test_random_traffic(200, 32'd0, 32'd200, 25, 0, 0);
		test_backpressure(40);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

[files.f]
sv/arpc_pkg.sv
sv/arpc_req_if.sv
sv/arpc_rsp_if.sv
sv/arp_cache_responder.sv
sim/tb.sv
